// ===== sv/calclk_pkg.sv =====
// Package: word types and constants for the calendar clock.
`default_nettype none

package calclk_pkg;

  localparam int UPTIME_WIDTH = 32;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic [3:0] DIGIT_MAX  = 4'd9;
  localparam logic [5:0] SEC_MAX    = 6'd59;
  localparam logic [5:0] MIN_MAX    = 6'd59;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [3:0] MONTH_WRAP = 4'd13;
  localparam logic [2:0] WDAY_MAX   = 3'd7;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  localparam logic [4:0] DAY_RESET   = 5'd20;
  localparam logic [3:0] MONTH_RESET = 4'd6;

  typedef struct packed {
    logic       opcode;
    logic [7:0] new_year;
    logic [3:0] new_month;
    logic [4:0] new_day;
    logic [4:0] new_hour;
    logic [5:0] new_minute;
    logic [5:0] new_second;
    logic [2:0] new_weekday;
  } req_t;

  typedef struct packed {
    logic [7:0]  year_now;
    logic [3:0]  month_now;
    logic [4:0]  day_now;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [9:0]  millis_now;
    logic [2:0]  weekday_now;
    logic [31:0] uptime_seconds;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/calendar_clock_tick_top.sv =====
// Top level: millisecond-tick calendar clock with set command.
// Each accepted word's result word is registered into rsp, valid the cycle after acceptance.
// Throughput: one word per cycle while rsp is not stalled; the digit counter cascade and the
//   day/month roll logic all settle between the clock state and rsp.
// Reset (rst, synchronous): time 00:00:00.000, day 20, month 6, year offset 0,
//   weekday 0, uptime 0, no result pending.
`default_nettype none

module calendar_clock_tick_top import calclk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // clock state
  logic [3:0]              ms_units, ms_tens, ms_hundreds;
  logic [5:0]              seconds, minutes;
  logic [4:0]              hours;
  logic [4:0]              day_of_month;
  logic [3:0]              month_of_year;
  logic [7:0]              year_offset;
  logic [2:0]              day_of_week;
  logic [UPTIME_WIDTH-1:0] seconds_since_reset;

  logic [3:0]              ms_units_next, ms_tens_next, ms_hundreds_next;
  logic [5:0]              seconds_next, minutes_next;
  logic [4:0]              hours_next;
  logic [4:0]              day_of_month_next;
  logic [3:0]              month_of_year_next;
  logic [7:0]              year_offset_next;
  logic [2:0]              day_of_week_next;
  logic [UPTIME_WIDTH-1:0] seconds_since_reset_next;

  logic accept;
  rsp_t rsp_next;

  // The result register is the only buffer: take a word whenever it is
  // empty or being drained this cycle.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // Carry cascade. Compares use >= so out-of-range set values roll over.
  logic units_wrap, tens_wrap, sec_tick, sec_wrap, min_wrap, day_tick;

  assign units_wrap = (ms_units >= DIGIT_MAX);
  assign tens_wrap  = units_wrap && (ms_tens >= DIGIT_MAX);
  assign sec_tick   = tens_wrap && (ms_hundreds >= DIGIT_MAX);
  assign sec_wrap   = sec_tick && (seconds >= SEC_MAX);
  assign min_wrap   = sec_wrap && (minutes >= MIN_MAX);
  assign day_tick   = min_wrap && (hours >= HOUR_MAX);

  // Next calendar day: increment, then end-of-month check per month.
  logic [4:0] day_inc;
  logic [3:0] month_inc;
  logic [3:0] month_roll;
  logic [2:0] wday_inc;
  logic       month_end;
  logic       year_wrap;

  always_comb begin
    day_inc = day_of_month + 5'd1;
    priority if (day_inc == 5'd0) begin
      month_end = 1'b1;                       // past day 31 in any month
    end else if (day_inc == 5'd31) begin
      month_end = (month_of_year == MONTH_APR) || (month_of_year == MONTH_JUN) ||
                  (month_of_year == MONTH_SEP) || (month_of_year == MONTH_NOV);
    end else if (day_inc == 5'd30) begin
      month_end = (month_of_year == MONTH_FEB);
    end else if (day_inc == 5'd29) begin
      month_end = (month_of_year == MONTH_FEB) && (year_offset[1:0] != 2'd0);
    end else begin
      month_end = 1'b0;
    end
    month_inc  = month_of_year + 4'd1;
    month_roll = month_end ? month_inc : month_of_year;
    year_wrap  = (month_roll == MONTH_WRAP);
    wday_inc   = day_of_week + 3'd1;
  end

  always_comb begin
    ms_units_next            = ms_units;
    ms_tens_next             = ms_tens;
    ms_hundreds_next         = ms_hundreds;
    seconds_next             = seconds;
    minutes_next             = minutes;
    hours_next               = hours;
    day_of_month_next        = day_of_month;
    month_of_year_next       = month_of_year;
    year_offset_next         = year_offset;
    day_of_week_next         = day_of_week;
    seconds_since_reset_next = seconds_since_reset;

    unique case (req.opcode)
      OP_SET: begin
        // sub-second digits and uptime are left alone
        year_offset_next   = req.new_year;
        month_of_year_next = req.new_month;
        day_of_month_next  = req.new_day;
        hours_next         = req.new_hour;
        minutes_next       = req.new_minute;
        seconds_next       = req.new_second;
        day_of_week_next   = req.new_weekday;
      end
      OP_TICK: begin
        ms_units_next = units_wrap ? 4'd0 : ms_units + 4'd1;
        if (units_wrap) begin
          ms_tens_next = tens_wrap ? 4'd0 : ms_tens + 4'd1;
        end
        if (tens_wrap) begin
          ms_hundreds_next = sec_tick ? 4'd0 : ms_hundreds + 4'd1;
        end
        if (sec_tick) begin
          seconds_since_reset_next = seconds_since_reset + 1'b1;
          seconds_next = sec_wrap ? 6'd0 : seconds + 6'd1;
        end
        if (sec_wrap) begin
          minutes_next = min_wrap ? 6'd0 : minutes + 6'd1;
        end
        if (min_wrap) begin
          hours_next = day_tick ? 5'd0 : hours + 5'd1;
        end
        if (day_tick) begin
          day_of_month_next  = month_end ? 5'd1 : day_inc;
          month_of_year_next = year_wrap ? 4'd1 : month_roll;
          if (year_wrap) begin
            year_offset_next = year_offset + 8'd1;
          end
          // weekday 7 wraps to 0 in three bits, which also maps to 1
          day_of_week_next = (wday_inc == 3'd0 || wday_inc > WDAY_MAX) ? 3'd1 : wday_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // Result word from the updated state.
  always_comb begin
    rsp_next.year_now       = year_offset_next;
    rsp_next.month_now      = month_of_year_next;
    rsp_next.day_now        = day_of_month_next;
    rsp_next.hour_now       = hours_next;
    rsp_next.minute_now     = minutes_next;
    rsp_next.second_now     = seconds_next;
    rsp_next.millis_now     = 10'(ms_hundreds_next) * 10'd100 + 10'(ms_tens_next) * 10'd10
                              + 10'(ms_units_next);
    rsp_next.weekday_now    = day_of_week_next;
    rsp_next.uptime_seconds = 32'(seconds_since_reset_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_units            <= '0;
      ms_tens             <= '0;
      ms_hundreds         <= '0;
      seconds             <= '0;
      minutes             <= '0;
      hours               <= '0;
      day_of_month        <= DAY_RESET;
      month_of_year       <= MONTH_RESET;
      year_offset         <= '0;
      day_of_week         <= '0;
      seconds_since_reset <= '0;
      rsp_valid           <= 1'b0;
    end else begin
      if (accept) begin
        ms_units            <= ms_units_next;
        ms_tens             <= ms_tens_next;
        ms_hundreds         <= ms_hundreds_next;
        seconds             <= seconds_next;
        minutes             <= minutes_next;
        hours               <= hours_next;
        day_of_month        <= day_of_month_next;
        month_of_year       <= month_of_year_next;
        year_offset         <= year_offset_next;
        day_of_week         <= day_of_week_next;
        seconds_since_reset <= seconds_since_reset_next;
        rsp_valid           <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/calendar_clock_tick_top_tb.sv =====
// Testbench for the calendar clock: directed table and random words, checked against a predictor.
`timescale 1ns / 1ps

module calendar_clock_tick_top_tb;
  import calclk_pkg::*;

  localparam int RANDOM_WORDS = 400;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // One row of the directed table. A row repeats its word reps times; a typed
  // row carries a hand-written expected time, others go to the predictor.
  typedef struct {
    req_t word;
    int   reps;
    bit   typed;
    rsp_t golden;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Travels with each request word: hand-written expectation, if any.
  logic word_typed = 1'b0;
  rsp_t word_golden = '0;

  // Predicted clock state.
  logic [3:0]  milli_d0, milli_d1, milli_d2;
  logic [5:0]  cal_sec, cal_min;
  logic [4:0]  cal_hour, cal_day;
  logic [3:0]  cal_month;
  logic [7:0]  cal_year;
  logic [2:0]  cal_wday;
  logic [31:0] cal_uptime;

  rsp_t      pending_times[$];
  step_row_t plan[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        steady = 1'b0;    // no idling on either side while set

  calendar_clock_tick_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("calendar_clock_tick_top_tb failed");
      $finish;
    end
  end

  // Receiver stalls about a quarter of the time, except in the steady stretch.
  always @(posedge clk) begin
    rsp_stall <= !steady && ($urandom_range(0, 99) < 24);
  end

  function automatic req_t set_cmd(int yr, int mo, int dy, int hr, int mi, int se, int wd);
    req_t w;
    w.opcode      = OP_SET;
    w.new_year    = yr[7:0];
    w.new_month   = mo[3:0];
    w.new_day     = dy[4:0];
    w.new_hour    = hr[4:0];
    w.new_minute  = mi[5:0];
    w.new_second  = se[5:0];
    w.new_weekday = wd[2:0];
    return w;
  endfunction

  function automatic rsp_t clock_at(int yr, int mo, int dy, int hr, int mi, int se, int ms,
                                    int wd, int up);
    rsp_t t;
    t.year_now       = yr[7:0];
    t.month_now      = mo[3:0];
    t.day_now        = dy[4:0];
    t.hour_now       = hr[4:0];
    t.minute_now     = mi[5:0];
    t.second_now     = se[5:0];
    t.millis_now     = ms[9:0];
    t.weekday_now    = wd[2:0];
    t.uptime_seconds = up;
    return t;
  endfunction

  // Tick with random junk in the fields the block ignores on a tick.
  function automatic req_t tick_word();
    logic [63:0] raw;
    req_t w;
    raw = {$urandom, $urandom};
    w = raw[$bits(req_t)-1:0];
    w.opcode = OP_TICK;
    return w;
  endfunction

  function automatic string show_time(rsp_t t);
    return $sformatf("y%0d m%0d d%0d %0d:%0d:%0d.%0d wd%0d up%0d", t.year_now, t.month_now,
                     t.day_now, t.hour_now, t.minute_now, t.second_now, t.millis_now,
                     t.weekday_now, t.uptime_seconds);
  endfunction

  // Predictor: applies one word to the clock state and returns the time after it.
  task automatic advance_clock(input req_t w, output rsp_t t);
    int         nxt;
    logic       carry;
    logic       roll;
    logic [4:0] d;
    logic [3:0] m;
    if (w.opcode == OP_SET) begin
      // set leaves the millisecond digits and the uptime alone
      cal_year  = w.new_year;
      cal_month = w.new_month;
      cal_day   = w.new_day;
      cal_hour  = w.new_hour;
      cal_min   = w.new_minute;
      cal_sec   = w.new_second;
      cal_wday  = w.new_weekday;
    end else begin
      milli_d0 = milli_d0 + 4'd1;
      carry = milli_d0 > DIGIT_MAX;
      if (carry) begin
        milli_d0 = 4'd0;
        milli_d1 = milli_d1 + 4'd1;
        carry = milli_d1 > DIGIT_MAX;
      end
      if (carry) begin
        milli_d1 = 4'd0;
        milli_d2 = milli_d2 + 4'd1;
        carry = milli_d2 > DIGIT_MAX;
      end
      // Second, minute and hour are bumped in int so a loaded 63 (or hour 31)
      // carries instead of wrapping to zero inside the field.
      if (carry) begin
        milli_d2 = 4'd0;
        cal_uptime = cal_uptime + 32'd1;
        nxt = int'(cal_sec) + 1;
        carry = nxt > int'(SEC_MAX);
        cal_sec = carry ? 6'd0 : nxt[5:0];
      end
      if (carry) begin
        nxt = int'(cal_min) + 1;
        carry = nxt > int'(MIN_MAX);
        cal_min = carry ? 6'd0 : nxt[5:0];
      end
      if (carry) begin
        nxt = int'(cal_hour) + 1;
        carry = nxt > int'(HOUR_MAX);
        cal_hour = carry ? 5'd0 : nxt[4:0];
      end
      if (carry) begin
        // day is bumped in 5 bits first, then the month end test is applied
        d = cal_day + 5'd1;
        m = cal_month;
        roll = (d == 5'd0)
            || (d == 5'd31 && (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP
                               || m == MONTH_NOV))
            || (d == 5'd30 && m == MONTH_FEB)
            || (d == 5'd29 && m == MONTH_FEB && cal_year[1:0] != 2'd0);
        if (roll) begin
          m = m + 4'd1;
          d = 5'd1;
        end
        if (m == MONTH_WRAP) begin
          m = 4'd1;
          cal_year = cal_year + 8'd1;
        end
        cal_day   = d;
        cal_month = m;
        cal_wday  = cal_wday + 3'd1;
        if (cal_wday == 3'd0) cal_wday = 3'd1;
      end
    end
    t.year_now       = cal_year;
    t.month_now      = cal_month;
    t.day_now        = cal_day;
    t.hour_now       = cal_hour;
    t.minute_now     = cal_min;
    t.second_now     = cal_sec;
    t.millis_now     = 10'(milli_d2) * 10'd100 + 10'(milli_d1) * 10'd10 + 10'(milli_d0);
    t.weekday_now    = cal_wday;
    t.uptime_seconds = cal_uptime;
  endtask

  // Predict on every accepted request word, check every accepted result word.
  always @(posedge clk) begin : track_clock
    rsp_t want;
    string bad;
    if (rst) begin
      milli_d0   = 4'd0;
      milli_d1   = 4'd0;
      milli_d2   = 4'd0;
      cal_sec    = 6'd0;
      cal_min    = 6'd0;
      cal_hour   = 5'd0;
      cal_day    = DAY_RESET;
      cal_month  = MONTH_RESET;
      cal_year   = 8'd0;
      cal_wday   = 3'd0;
      cal_uptime = 32'd0;
      pending_times.delete();
    end else begin
      if (req_valid && !req_stall) begin
        advance_clock(req, want);
        pending_times.push_back(word_typed ? word_golden : want);
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_times.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected time word %s", $time, show_time(rsp));
        end else begin
          want = pending_times.pop_front();
          bad = "";
          if (rsp.year_now !== want.year_now) bad = {bad, " year"};
          if (rsp.month_now !== want.month_now) bad = {bad, " month"};
          if (rsp.day_now !== want.day_now) bad = {bad, " day"};
          if (rsp.hour_now !== want.hour_now) bad = {bad, " hour"};
          if (rsp.minute_now !== want.minute_now) bad = {bad, " minute"};
          if (rsp.second_now !== want.second_now) bad = {bad, " second"};
          if (rsp.millis_now !== want.millis_now) bad = {bad, " millis"};
          if (rsp.weekday_now !== want.weekday_now) bad = {bad, " weekday"};
          if (rsp.uptime_seconds !== want.uptime_seconds) bad = {bad, " uptime"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: time word mismatch in%s\n  expected %s\n  actual   %s", $time, bad,
                       show_time(want), show_time(rsp));
          end
        end
      end
    end
  end

  // Sender: random gaps, then hold the word until it is taken.
  task automatic send_word(input req_t w, input bit typed, input rsp_t golden);
    while (!steady && $urandom_range(0, 99) < 24) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    req         <= w;
    word_typed  <= typed;
    word_golden <= golden;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic plan_row(input req_t w, input int reps, input bit typed, input rsp_t golden);
    step_row_t r;
    r.word   = w;
    r.reps   = reps;
    r.typed  = typed;
    r.golden = golden;
    plan.push_back(r);
  endtask

  initial begin : stimulus
    req_t w;
    int   pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table. A second takes a thousand ticks, so the one millisecond
    // wrap in the table carries a set that rolls every calendar field at once.
    // reset state, weekday still 0 before any day change
    plan_row(tick_word(), 1, 1'b1, clock_at(0, 6, 20, 0, 0, 0, 1, 0, 0));
    plan_row(tick_word(), 997, 1'b0, '0);
    plan_row(tick_word(), 1, 1'b1, clock_at(0, 6, 20, 0, 0, 0, 999, 0, 0));
    // last second of year 255, weekday 7, one tick short of the wrap
    plan_row(set_cmd(255, 12, 31, 23, 59, 59, 7), 1, 1'b1,
             clock_at(255, 12, 31, 23, 59, 59, 999, 7, 0));
    // first millisecond wrap: uptime steps, year and weekday both wrap
    plan_row(tick_word(), 1, 1'b1, clock_at(0, 1, 1, 0, 0, 0, 0, 1, 1));
    // set with every field zero
    plan_row(set_cmd(0, 0, 0, 0, 0, 0, 0), 1, 1'b1, clock_at(0, 0, 0, 0, 0, 0, 0, 0, 1));
    // all-ones set: out of range values load as given
    plan_row(set_cmd(255, 15, 31, 31, 63, 63, 7), 1, 1'b1,
             clock_at(255, 15, 31, 31, 63, 63, 0, 7, 1));
    // a tick after the all-ones set moves only the millisecond digits
    plan_row(tick_word(), 1, 1'b1, clock_at(255, 15, 31, 31, 63, 63, 1, 7, 1));

    foreach (plan[i]) begin
      repeat (plan[i].reps) begin
        w = (plan[i].word.opcode == OP_TICK) ? tick_word() : plan[i].word;
        send_word(w, plan[i].typed, plan[i].golden);
      end
    end

    // Random part: ticks mixed with sets, all checked by the predictor.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= 100 && n < 300);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_word(tick_word(), 1'b0, '0);
      end else begin
        // mostly in range, a quarter of the sets take any bit pattern
        w = tick_word();
        if ($urandom_range(0, 3) != 0)
          w = set_cmd($urandom_range(0, 255), $urandom_range(1, 12), $urandom_range(1, 31),
                      $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                      $urandom_range(1, 7));
        w.opcode = OP_SET;
        send_word(w, 1'b0, '0);
      end
    end
    steady = 1'b0;
    req_valid <= 1'b0;

    // drain, then keep waiting to catch stray result words
    @(posedge clk);
    while (pending_times.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_times.size() == 0)
      $display("calendar_clock_tick_top_tb passed");
    else
      $display("calendar_clock_tick_top_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/calclk_pkg.sv
sv/calendar_clock_tick_top.sv
tb/sv/calendar_clock_tick_top_tb.sv
